@@ design/tmtw_pkg.sv @@
`default_nettype none

package tmtw_pkg;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0] NEWLINE_CODE     = 8'h0A;
    localparam logic [7:0] SPACE_CODE       = 8'h20;
    localparam logic [7:0] TEXT_COLOR_RESET = 8'd15;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_OUTSTANDING = QUEUE_DEPTH + 1;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ,
        OP_CLEAR,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  char_code;
        logic        last_of_string;
        logic [10:0] read_address;
    } entry_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

@@ design/tmtw_front.sv @@
`default_nettype none

module tmtw_front
    import tmtw_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_cmd,
    input  wire  [7:0]  s_char_code,
    input  wire         s_last_of_string,
    input  wire  [10:0] s_read_address,
    output logic        q_valid,
    input  wire         q_ready,
    output entry_t      q_data
);

    entry_t                 queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;
    entry_t                 entry_in;

    localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);

    always_comb begin
        entry_in.char_code      = s_char_code;
        entry_in.last_of_string = s_last_of_string;
        entry_in.read_address   = s_read_address;
        unique case (s_cmd)
            CMD_PUT:   entry_in.op = (s_char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
            CMD_READ:  entry_in.op = OP_READ;
            CMD_CLEAR: entry_in.op = OP_CLEAR;
            default:   entry_in.op = OP_NONE;
        endcase
    end

    assign s_ready = (count_reg != FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_data  = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

`default_nettype wire

@@ design/tmtw_back.sv @@
`default_nettype none

module tmtw_back
    import tmtw_pkg::*;
#(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    input  wire  [7:0]  cfg_data,
    input  wire         q_valid,
    output logic        q_ready,
    input  entry_t      q_data,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attribute,
    output logic [10:0] m_cursor_offset
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SUM_W  = ADDR_W + 1;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_LEN       = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_LAST_OFS  = ADDR_W'(COLUMNS - 1);
    localparam logic [SUM_W-1:0]  CELLS_S       = SUM_W'(CELLS);

    logic [7:0] screen_mem [CELLS];
    logic [7:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] lin_reg, lin_next;
    logic [ADDR_W-1:0] top_reg, top_next;
    logic [ADDR_W-1:0] hw_reg, hw_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [7:0]        text_color_reg;
    logic              rd_ok_reg, rd_ok_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic [7:0]        out_attr_reg, out_attr_next;
    logic [10:0]       out_cursor_reg, out_cursor_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              slot_free;
    logic [SUM_W-1:0]  cur_sum;
    logic [ADDR_W-1:0] cur_phys;
    logic [SUM_W-1:0]  rd_sum;
    logic [ADDR_W-1:0] rd_phys;
    logic              rd_in_range;
    logic [SUM_W-1:0]  top_sum;
    logic [ADDR_W-1:0] top_wrapped;
    logic [ADDR_W-1:0] next_line;
    logic [ADDR_W-1:0] nl_lin;
    logic              nl_scroll;

    // The screen is a ring of rows: top_reg is the physical offset of the first row.
    always_comb begin
        cur_sum     = {1'b0, lin_reg} + {1'b0, top_reg};
        cur_phys    = (cur_sum >= CELLS_S) ? ADDR_W'(cur_sum - CELLS_S) : ADDR_W'(cur_sum);
        rd_in_range = (32'(q_data.read_address) < 32'(CELLS));
        rd_sum      = SUM_W'(q_data.read_address) + {1'b0, top_reg};
        rd_phys     = (rd_sum >= CELLS_S) ? ADDR_W'(rd_sum - CELLS_S) : ADDR_W'(rd_sum);
        top_sum     = {1'b0, top_reg} + {1'b0, ROW_LEN};
        top_wrapped = (top_sum >= CELLS_S) ? ADDR_W'(top_sum - CELLS_S) : ADDR_W'(top_sum);
        next_line   = lin_reg - ADDR_W'(col_reg) + ROW_LEN;
        nl_scroll   = (row_reg == LAST_ROW);
        nl_lin      = nl_scroll ? LAST_ROW_BASE : next_line;
    end

    assign slot_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        lin_next        = lin_reg;
        top_next        = top_reg;
        hw_next         = hw_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        rd_ok_next      = rd_ok_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_char_next   = out_char_reg;
        out_attr_next   = out_attr_reg;
        out_cursor_next = out_cursor_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = SPACE_CODE;
        mem_re          = 1'b0;
        mem_raddr       = rd_phys;
        q_ready         = 1'b0;

        unique case (state_reg)
            ST_SWEEP: begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == end_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                out_valid_next  = 1'b1;
                out_char_next   = rd_ok_reg ? rd_data_reg : 8'd0;
                out_attr_next   = text_color_reg;
                out_cursor_next = 11'(hw_reg);
                state_next      = ST_IDLE;
            end
            ST_IDLE: begin
                if (q_valid && slot_free) begin
                    q_ready         = 1'b1;
                    out_valid_next  = 1'b1;
                    out_char_next   = 8'd0;
                    out_attr_next   = 8'd0;
                    out_cursor_next = 11'(hw_reg);
                    unique case (q_data.op) inside
                        OP_PUT, OP_NEWLINE: begin
                            if (q_data.op == OP_PUT) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_phys;
                                mem_wdata = q_data.char_code;
                            end
                            if (q_data.op == OP_PUT && col_reg != LAST_COL) begin
                                col_next = col_reg + 1'b1;
                                lin_next = lin_reg + 1'b1;
                            end else begin
                                col_next = '0;
                                lin_next = nl_lin;
                                if (nl_scroll) begin
                                    ptr_next   = top_reg;
                                    end_next   = top_reg + ROW_LAST_OFS;
                                    top_next   = top_wrapped;
                                    state_next = ST_SWEEP;
                                end else begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            if (q_data.last_of_string) begin
                                hw_next         = lin_next;
                                out_cursor_next = 11'(lin_next);
                            end
                        end
                        OP_READ: begin
                            out_valid_next = 1'b0;
                            mem_re         = 1'b1;
                            rd_ok_next     = rd_in_range;
                            state_next     = ST_READ;
                        end
                        OP_CLEAR: begin
                            row_next        = '0;
                            col_next        = '0;
                            lin_next        = '0;
                            top_next        = '0;
                            hw_next         = '0;
                            ptr_next        = '0;
                            end_next        = LAST_CELL;
                            out_cursor_next = 11'd0;
                            state_next      = ST_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            row_reg        <= '0;
            col_reg        <= '0;
            lin_reg        <= '0;
            top_reg        <= '0;
            hw_reg         <= '0;
            ptr_reg        <= '0;
            end_reg        <= LAST_CELL;
            rd_ok_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            text_color_reg <= TEXT_COLOR_RESET;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            lin_reg       <= lin_next;
            top_reg       <= top_next;
            hw_reg        <= hw_next;
            ptr_reg       <= ptr_next;
            end_reg       <= end_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                text_color_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_char_reg   <= out_char_next;
        out_attr_reg   <= out_attr_next;
        out_cursor_reg <= out_cursor_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_cell_char      = out_char_reg;
    assign m_cell_attribute = out_attr_reg;
    assign m_cursor_offset  = out_cursor_reg;

endmodule

`default_nettype wire

@@ design/text_mode_terminal_writer_top.sv @@
// A put, newline or unused command is handled in the idle state; a read also passes through
// the read state because the screen memory read is registered; a newline or wrap on the last row
// adds a sweep that blanks the recycled row, and a clear adds a sweep of the whole screen.
// An input beat reaches its result beat through the queue and the output registers.
// After reset the back end fills the screen memory with spaces;
// input beats queue up meanwhile and configuration beats are taken at once.
`default_nettype none

module text_mode_terminal_writer_top
    import tmtw_pkg::*;
#(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_cmd,
    input  wire  [7:0]  s_char_code,
    input  wire         s_last_of_string,
    input  wire  [10:0] s_read_address,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attribute,
    output logic [10:0] m_cursor_offset
);

    logic   q_valid;
    logic   q_ready;
    entry_t q_data;

    assign cfg_ready = 1'b1;

    tmtw_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_char_code      (s_char_code),
        .s_last_of_string (s_last_of_string),
        .s_read_address   (s_read_address),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_data           (q_data)
    );

    tmtw_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_data           (q_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cell_char      (m_cell_char),
        .m_cell_attribute (m_cell_attribute),
        .m_cursor_offset  (m_cursor_offset)
    );

endmodule

`default_nettype wire

@@ design/tmtw_checker.sv @@
`default_nettype none

module tmtw_checker
    import tmtw_pkg::*;
#(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [7:0]  m_cell_char,
    input wire [7:0]  m_cell_attribute,
    input wire [10:0] m_cursor_offset
);

    localparam int CELLS = ROWS * COLUMNS;

    logic [2:0] outstanding_reg;
    logic [2:0] outstanding_next;

    always_comb begin
        outstanding_next = outstanding_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            outstanding_next = outstanding_reg + 1'b1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A stalled result beat must hold its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_char)
            && $stable(m_cell_attribute) && $stable(m_cursor_offset))
        else $error("result beat changed while stalled");

    // Every result beat answers an input beat that is still open.
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> outstanding_reg != 3'd0)
        else $error("result beat without a pending input beat");

    // The queue plus the back end bound the number of open beats.
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(outstanding_reg) <= MAX_OUTSTANDING)
        else $error("too many input beats in flight");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CELLS > 2048) || (32'(m_cursor_offset) < 32'(CELLS)))
        else $error("cursor offset outside the screen");

endmodule

bind text_mode_terminal_writer_top tmtw_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
) u_tmtw_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_cell_char      (m_cell_char),
    .m_cell_attribute (m_cell_attribute),
    .m_cursor_offset  (m_cursor_offset)
);

`default_nettype wire

@@ tb/text_mode_terminal_writer_top_test.sv @@
`timescale 1ns / 1ps

module text_mode_terminal_writer_top_test;
    import tmtw_pkg::*;

    localparam int ROWS = 25;
    localparam int COLUMNS = 80;
    localparam int CELLS = ROWS * COLUMNS;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 630;
    localparam int PHASES = 6;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 16;

    typedef struct {
        logic [7:0]  cell_char;
        logic [7:0]  cell_attribute;
        logic [10:0] cursor_offset;
    } cell_result_t;

    class terminal_scoreboard;
        logic [7:0] screen [CELLS];
        int unsigned row;
        int unsigned column;
        logic [10:0] hw_cursor;
        logic [7:0] color;
        cell_result_t expected_cells[$];
        int errors;
        int puts;
        int newlines;
        int wraps;
        int scrolls;
        int reads;
        int clears;
        int checked;

        function void clear_screen();
            foreach (screen[i]) screen[i] = SPACE_CODE;
            row = 0;
            column = 0;
            hw_cursor = '0;
        endfunction

        function void next_row();
            column = 0;
            if (row + 1 >= ROWS) begin
                for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
                for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = SPACE_CODE;
                scrolls++;
            end else begin
                row++;
            end
        endfunction

        function void note_input(logic [1:0] cmd, logic [7:0] code, logic last,
                                 logic [10:0] addr);
            cell_result_t r;
            r.cell_char = '0;
            r.cell_attribute = '0;
            case (cmd)
                CMD_PUT: begin
                    puts++;
                    if (code == NEWLINE_CODE) begin
                        newlines++;
                        next_row();
                    end else begin
                        screen[row * COLUMNS + column] = code;
                        column++;
                        if (column >= COLUMNS) begin
                            wraps++;
                            next_row();
                        end
                    end
                    if (last) hw_cursor = 11'(row * COLUMNS + column);
                end
                CMD_READ: begin
                    reads++;
                    if (addr < CELLS) r.cell_char = screen[addr];
                    r.cell_attribute = color;
                end
                CMD_CLEAR: begin
                    clears++;
                    clear_screen();
                end
                default: begin
                end
            endcase
            r.cursor_offset = hw_cursor;
            expected_cells.push_back(r);
        endfunction

        function void check_result(logic [7:0] cell_char, logic [7:0] cell_attribute,
                                   logic [10:0] cursor_offset);
            cell_result_t e;
            if (expected_cells.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            e = expected_cells.pop_front();
            checked++;
            if (cell_char !== e.cell_char) begin
                $error("cell_char: expected %0h, actual %0h", e.cell_char, cell_char);
                errors++;
            end
            if (cell_attribute !== e.cell_attribute) begin
                $error("cell_attribute: expected %0h, actual %0h",
                       e.cell_attribute, cell_attribute);
                errors++;
            end
            if (cursor_offset !== e.cursor_offset) begin
                $error("cursor_offset: expected %0d, actual %0d",
                       e.cursor_offset, cursor_offset);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_cmd = '0;
    logic [7:0] s_char_code = '0;
    logic s_last_of_string = 1'b0;
    logic [10:0] s_read_address = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_cell_char;
    logic [7:0] m_cell_attribute;
    logic [10:0] m_cursor_offset;

    logic steady = 1'b0;
    int string_left = 0;
    int newline_pct = 0;
    int settings = 1;
    int unsigned quiet_cycles = 0;
    terminal_scoreboard sb;

    text_mode_terminal_writer_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_char_code      (s_char_code),
        .s_last_of_string (s_last_of_string),
        .s_read_address   (s_read_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cell_char      (m_cell_char),
        .m_cell_attribute (m_cell_attribute),
        .m_cursor_offset  (m_cursor_offset)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready = steady || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        if (aresetn && sb != null) begin
            if (cfg_valid && cfg_ready) sb.color = cfg_data;
            if (s_valid && s_ready)
                sb.note_input(s_cmd, s_char_code, s_last_of_string, s_read_address);
            if (m_valid && m_ready)
                sb.check_result(m_cell_char, m_cell_attribute, m_cursor_offset);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [7:0] code, logic last,
                             logic [10:0] addr);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 6) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_cmd = cmd;
        s_char_code = code;
        s_last_of_string = last;
        s_read_address = addr;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_color(logic [7:0] value);
        @(negedge aclk);
        s_valid = 1'b0;
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_cells.size() != 0) @(posedge aclk);
    endtask

    task automatic directed_items();
        send_item(CMD_READ, 8'h00, 1'b1, 11'd0);
        send_item(CMD_READ, 8'hFF, 1'b0, 11'(CELLS - 1));
        send_item(CMD_READ, 8'h00, 1'b0, 11'(CELLS));
        send_item(CMD_READ, 8'hFF, 1'b1, 11'h7FF);
        send_item(CMD_PUT, 8'h00, 1'b0, 11'h7FF);
        send_item(CMD_PUT, 8'hFF, 1'b1, 11'd0);
        send_item(CMD_UNUSED, 8'hFF, 1'b1, 11'h7FF);
        send_item(CMD_READ, 8'h00, 1'b1, 11'd1);
        send_item(CMD_PUT, NEWLINE_CODE, 1'b1, 11'd0);
        send_item(CMD_PUT, 8'h41, 1'b0, 11'd0);
        send_item(CMD_READ, 8'h00, 1'b0, 11'(COLUMNS));
        send_item(CMD_READ, 8'h00, 1'b0, 11'd0);
        send_item(CMD_UNUSED, 8'h00, 1'b0, 11'd0);
        send_item(CMD_CLEAR, 8'hFF, 1'b1, 11'h7FF);
        send_item(CMD_READ, 8'h00, 1'b0, 11'd1);
        send_item(CMD_PUT, 8'h7F, 1'b1, 11'd0);
        send_item(CMD_PUT, NEWLINE_CODE, 1'b0, 11'd0);
        send_item(CMD_READ, 8'h00, 1'b1, 11'd0);
    endtask

    // Most puts form strings of random length that end on a last-of-string beat; a string
    // has no newlines to force wraps, newlines at 8 percent, or is dense with them (40 percent) to scroll.
    task automatic random_item();
        logic [1:0] cmd;
        logic [7:0] code;
        logic last;
        logic [10:0] addr;
        int pick;
        pick = $urandom_range(999);
        code = 8'($urandom_range(255));
        last = 1'($urandom_range(1));
        addr = 11'($urandom_range(CELLS - 1));
        if (pick < 5) begin
            cmd = CMD_CLEAR;
        end else if (pick < 35) begin
            cmd = CMD_UNUSED;
        end else if (pick < 230) begin
            cmd = CMD_READ;
            pick = $urandom_range(99);
            if (pick < 45) addr = 11'(sb.row * COLUMNS + $urandom_range(COLUMNS - 1));
            else if (pick < 55) addr = 11'($urandom_range(2047, CELLS));
        end else begin
            cmd = CMD_PUT;
            if (string_left == 0) begin
                string_left = ($urandom_range(3) == 0) ? $urandom_range(180, 60)
                                                       : $urandom_range(16, 1);
                pick = $urandom_range(2);
                newline_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 40;
            end
            if ($urandom_range(99) < newline_pct) code = NEWLINE_CODE;
            if ($urandom_range(9) != 0) last = (string_left == 1);
            string_left--;
        end
        send_item(cmd, code, last, addr);
    endtask

    initial begin
        sb = new();
        sb.color = TEXT_COLOR_RESET;
        sb.clear_screen();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        directed_items();
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            if (phase == 0) write_color(8'h00);
            else if (phase == 1) write_color(8'hFF);
            else write_color(8'($urandom_range(255)));
            settings++;
            steady = (phase == 2);
            repeat (RANDOM_ITEMS / PHASES) random_item();
        end
        drain();
        steady = 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Covered %0d puts (%0d newlines, %0d wraps, %0d scrolls), %0d reads, %0d clears",
                 sb.puts, sb.newlines, sb.wraps, sb.scrolls, sb.reads, sb.clears);
        $display("Checked %0d result beats under %0d color settings", sb.checked, settings);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
